@@ src/rtb_pkg.sv @@
package rtb_pkg;

    // Payload buffer geometry
    localparam int BUF_BYTES = 256;
    localparam int AW        = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int FILL_W    = $clog2(BUF_BYTES + 1);

    // Reset values
    localparam logic [15:0] TIMEOUT_RESET   = 16'd300;
    localparam logic [7:0]  TRY_LIMIT_RESET = 8'd10;

    // Register port: byte address, word index in the upper bits
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_TIMEOUT_IDX = '0;

    typedef enum logic [1:0] {
        REQ_STORE = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_ACK   = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef struct packed {
        logic       resend;
        logic       gave_up;
        logic       ack_matched;
        logic       pending;
        logic [7:0] cur_seq;
        logic [7:0] next_seq;
        logic [7:0] command_out;
        logic [8:0] length_out;
        logic [7:0] tries_done;
    } t_result;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [7:0]    data;
    } t_mem_wr;

endpackage

@@ src/rtb_msg_ctrl.sv @@
module rtb_msg_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  rtb_pkg::t_req        i_req,
    input  logic [31:0]          i_now_ms,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_byte_valid,
    input  logic                 i_last_byte,
    input  logic [7:0]           i_command,
    input  logic [7:0]           i_max_tries,
    input  logic [7:0]           i_ack_seq,
    input  logic [15:0]          i_timeout_ms,
    output rtb_pkg::t_result     o_result,
    output rtb_pkg::t_mem_wr     o_mem_wr
);
    import rtb_pkg::*;

    // Message state
    logic [FILL_W-1:0] r_len, n_len;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_building, n_building;
    logic [7:0]        r_seq, n_seq;
    logic [7:0]        r_cmd, n_cmd;
    logic [7:0]        r_tries, n_tries;
    logic [7:0]        r_limit, n_limit;
    logic [31:0]       r_last_send, n_last_send;

    logic [FILL_W-1:0] fill_base;
    logic              wr_en;
    logic [31:0]       elapsed;
    logic              resend, gave_up, matched;

    assign fill_base = r_building ? r_fill : '0;
    assign wr_en     = (i_req == REQ_STORE) && i_byte_valid
                       && (fill_base < FILL_W'(BUF_BYTES));
    assign elapsed   = i_now_ms - r_last_send;

    // Next message state for the item at the input
    always_comb begin
        n_len       = r_len;
        n_fill      = r_fill;
        n_building  = r_building;
        n_seq       = r_seq;
        n_cmd       = r_cmd;
        n_tries     = r_tries;
        n_limit     = r_limit;
        n_last_send = r_last_send;
        resend      = 1'b0;
        gave_up     = 1'b0;
        matched     = 1'b0;
        unique case (i_req)
            REQ_STORE: begin
                n_fill = fill_base + FILL_W'(wr_en);
                if (i_last_byte) begin
                    n_seq       = r_seq + 8'd1;
                    n_cmd       = i_command;
                    n_len       = n_fill;
                    n_tries     = '0;
                    n_limit     = i_max_tries;
                    n_last_send = i_now_ms;
                    n_building  = 1'b0;
                end else begin
                    // first byte of a message cancels the pending one
                    if (!r_building) begin
                        n_len = '0;
                    end
                    n_building = 1'b1;
                end
            end
            REQ_TICK: begin
                if (r_len != '0) begin
                    if (r_tries >= r_limit) begin
                        n_len   = '0;
                        gave_up = 1'b1;
                    end else if (elapsed >= {16'd0, i_timeout_ms}) begin
                        n_tries     = r_tries + 8'd1;
                        n_last_send = i_now_ms;
                        resend      = 1'b1;
                    end
                end
            end
            REQ_ACK: begin
                if ((i_ack_seq == r_seq) && (r_len != '0)) begin
                    n_len   = '0;
                    matched = 1'b1;
                end
            end
            REQ_READ: begin
            end
            default: begin
            end
        endcase
    end

    // Hold state, advance on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_fill      <= '0;
            r_building  <= 1'b0;
            r_seq       <= '0;
            r_cmd       <= '0;
            r_tries     <= '0;
            r_limit     <= TRY_LIMIT_RESET;
            r_last_send <= '0;
        end else if (i_accept) begin
            r_len       <= n_len;
            r_fill      <= n_fill;
            r_building  <= n_building;
            r_seq       <= n_seq;
            r_cmd       <= n_cmd;
            r_tries     <= n_tries;
            r_limit     <= n_limit;
            r_last_send <= n_last_send;
        end
    end

    // Result fields reflect the state after the update
    always_comb begin
        o_result.resend      = resend;
        o_result.gave_up     = gave_up;
        o_result.ack_matched = matched;
        o_result.pending     = (n_len != '0);
        o_result.cur_seq     = n_seq;
        o_result.next_seq    = n_seq + 8'd1;
        o_result.command_out = n_cmd;
        o_result.length_out  = 9'(n_len);
        o_result.tries_done  = n_tries;
    end

    // Buffer write for a stored byte
    always_comb begin
        o_mem_wr.en   = wr_en && i_accept;
        o_mem_wr.addr = AW'(fill_base);
        o_mem_wr.data = i_data_byte;
    end

endmodule

@@ src/retransmit_timer_buffer.sv @@
// Stop-and-wait retransmission buffer for one outgoing message.
//
// Input channel (i_in_valid / o_in_stall) carries one request per transfer:
// store a payload byte, time tick, acknowledgement, or read a buffered byte.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// request, in order. A transfer happens when valid is high and stall is low.
//
// A taken request's result is held in the middle stage (message update and buffer
// read) and then in the output register, from which it is presented.
// Throughput: one request per cycle while the output is not stalled; the payload buffer is a single-port
// style memory with one write or one registered read per request.
//
// When the receiver stalls, the output register holds its result and the
// middle stage still drains into it if empty; once both are full the input
// is stalled. No result is dropped or repeated.
//
// Reset (synchronous, active low) clears the message state, sets the try
// limit to 10 and timeout_ms to 300. Buffer contents are not cleared.
// timeout_ms is written through the APB port at byte address 0.
module retransmit_timer_buffer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_req_type,
    input  logic [31:0]                  i_now_ms,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_byte_valid,
    input  logic                         i_last_byte,
    input  logic [7:0]                   i_command,
    input  logic [7:0]                   i_max_tries,
    input  logic [7:0]                   i_ack_seq,
    input  logic [7:0]                   i_read_index,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_resend,
    output logic                         o_gave_up,
    output logic                         o_ack_matched,
    output logic                         o_pending,
    output logic [7:0]                   o_cur_seq,
    output logic [7:0]                   o_next_seq,
    output logic [7:0]                   o_command_out,
    output logic [8:0]                   o_length_out,
    output logic [7:0]                   o_tries_done,
    output logic [7:0]                   o_read_data,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rtb_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import rtb_pkg::*;

    logic [15:0] r_timeout_ms;
    logic        cfg_wr;
    logic        in_accept;
    logic        s1_adv;
    logic        rd_hit;

    logic        r_s1_v;
    t_result     r_s1_res;
    logic [7:0]  r_s1_rdata;
    logic        r_s2_v;
    t_result     r_s2_res;
    logic [7:0]  r_s2_rdata;

    t_result     core_res;
    t_mem_wr     mem_wr;
    t_req        req;

    logic [7:0]  r_mem [BUF_BYTES];

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[PADDR_W-1:2] == REG_TIMEOUT_IDX);
    assign prdata = (paddr[PADDR_W-1:2] == REG_TIMEOUT_IDX) ? {16'd0, r_timeout_ms}
                                                             : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms <= TIMEOUT_RESET;
        end else if (cfg_wr) begin
            r_timeout_ms <= pwdata[15:0];
        end
    end

    // Handshake: middle stage moves on when the output register frees up
    assign s1_adv     = r_s1_v && (!r_s2_v || !i_out_stall);
    assign o_in_stall = r_s1_v && !s1_adv;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign req        = t_req'(i_req_type);

    rtb_msg_ctrl u_msg_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_req        (req),
        .i_now_ms     (i_now_ms),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_last_byte  (i_last_byte),
        .i_command    (i_command),
        .i_max_tries  (i_max_tries),
        .i_ack_seq    (i_ack_seq),
        .i_timeout_ms (r_timeout_ms),
        .o_result     (core_res),
        .o_mem_wr     (mem_wr)
    );

    // Payload buffer: one write or one registered read per transfer
    assign rd_hit = (req == REQ_READ) && (32'(i_read_index) < BUF_BYTES);

    always_ff @(posedge i_clk) begin
        if (mem_wr.en) begin
            r_mem[mem_wr.addr] <= mem_wr.data;
        end
        if (in_accept) begin
            if (rd_hit) begin
                r_s1_rdata <= r_mem[AW'(i_read_index)];
            end else begin
                r_s1_rdata <= 8'd0;
            end
        end
    end

    // Middle stage: hold the result of the accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_accept) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_res <= core_res;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s1_adv) begin
            r_s2_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_s2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_res   <= r_s1_res;
            r_s2_rdata <= r_s1_rdata;
        end
    end

    assign o_out_valid   = r_s2_v;
    assign o_resend      = r_s2_res.resend;
    assign o_gave_up     = r_s2_res.gave_up;
    assign o_ack_matched = r_s2_res.ack_matched;
    assign o_pending     = r_s2_res.pending;
    assign o_cur_seq     = r_s2_res.cur_seq;
    assign o_next_seq    = r_s2_res.next_seq;
    assign o_command_out = r_s2_res.command_out;
    assign o_length_out  = r_s2_res.length_out;
    assign o_tries_done  = r_s2_res.tries_done;
    assign o_read_data   = r_s2_rdata;

endmodule

@@ src/rtb_checker.sv @@
module rtb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic        o_resend,
    input  logic        o_gave_up,
    input  logic        o_ack_matched,
    input  logic        o_pending,
    input  logic [7:0]  o_cur_seq,
    input  logic [7:0]  o_next_seq,
    input  logic [8:0]  o_length_out
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // A tick either resends or gives up, never both
    a_tick_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_resend && o_gave_up))
        else $error("resend and gave_up together");

    // Next sequence number follows the current one
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_next_seq == o_cur_seq + 8'd1))
        else $error("next_seq does not follow cur_seq");

    // Pending agrees with the stored length
    a_pend_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pending == (o_length_out != 9'd0)))
        else $error("pending disagrees with length");

    // A matched ack or a give-up leaves nothing pending
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_ack_matched || o_gave_up) |-> !o_pending)
        else $error("message still pending after clear");

endmodule

bind retransmit_timer_buffer rtb_checker u_rtb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_resend      (o_resend),
    .o_gave_up     (o_gave_up),
    .o_ack_matched (o_ack_matched),
    .o_pending     (o_pending),
    .o_cur_seq     (o_cur_seq),
    .o_next_seq    (o_next_seq),
    .o_length_out  (o_length_out)
);
